@@ hw/rtl/sfc_pkg.sv @@
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared widths, constants and command codes of the stereo FIR convolver.
// ----------------------------------------------------------------------------
package sfc_pkg;

	localparam int TAP_DEPTH_DEF = 1024;
	localparam int CHANNELS_DEF  = 2;

	localparam int CMD_W  = 2;
	localparam int CH_W   = 3;
	localparam int SMP_W  = 24;
	localparam int TIDX_W = 10;
	localparam int TAP_W  = 19;
	localparam int TLEN_W = 11;
	localparam int OUT_W  = 32;
	localparam int CC_W   = 2;

	// Q2.16 unity and the 1.5 normalization threshold
	localparam int ONE_Q16    = 65536;
	localparam int PEAK_LIMIT = 98304;

	// tap rescale divider: quotient never exceeds 1.0 in Q2.16
	localparam int QUO_W  = 17;
	localparam int REM_W  = 20;
	localparam int DIVD_W = 36;

	typedef enum logic [CMD_W-1:0] {
		CMD_SAMPLE  = 2'd0,
		CMD_ADVANCE = 2'd1,
		CMD_LOAD    = 2'd2,
		CMD_COMMIT  = 2'd3
	} cmd_t;

endpackage

@@ hw/rtl/sfc_in_if.sv @@
// ----------------------------------------------------------------------------
// sfc_in_if
// Command and sample channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfc_in_if;
	import sfc_pkg::*;

	logic                     valid;
	logic                     ready;
	cmd_t                     cmd;
	logic [CH_W-1:0]          channel;
	logic signed [SMP_W-1:0]  sample_in;
	logic [TIDX_W-1:0]        tap_index;
	logic signed [TAP_W-1:0]  tap_left;
	logic signed [TAP_W-1:0]  tap_right;
	logic [TLEN_W-1:0]        tap_length;

	modport source (output valid, cmd, channel, sample_in, tap_index, tap_left, tap_right,
		tap_length, input ready);
	modport sink (input valid, cmd, channel, sample_in, tap_index, tap_left, tap_right,
		tap_length, output ready);

endinterface

@@ hw/rtl/sfc_out_if.sv @@
// ----------------------------------------------------------------------------
// sfc_out_if
// Filtered sample channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfc_out_if;
	import sfc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [OUT_W-1:0]  sample_out;
	logic                     clipped;
	logic                     bypassed;

	modport source (output valid, sample_out, clipped, bypassed, input ready);
	modport sink (input valid, sample_out, clipped, bypassed, output ready);

endinterface

@@ hw/rtl/sfc_cfg_if.sv @@
// ----------------------------------------------------------------------------
// sfc_cfg_if
// Write channel for the channel count register.
// ----------------------------------------------------------------------------
interface sfc_cfg_if;
	import sfc_pkg::*;

	logic             valid;
	logic             ready;
	logic [CC_W-1:0]  data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);

endinterface

@@ hw/rtl/stereo_fir_convolver_core.sv @@
// ----------------------------------------------------------------------------
// stereo_fir_convolver_core
// Direct-form FIR over a shared interleaved sample ring, one MAC, tap rescale.
// ----------------------------------------------------------------------------
// A sample word (cmd 0) is stored in the ring and then one shared multiplier
// walks the active taps, one tap per cycle, out of the tap and ring memories;
// no next word is taken until its result has entered the output register, and
// an out-of-range channel passes its sample straight through. A commit sweeps
// the ring, one entry a cycle, then scans the taps for the peak and, if it is
// above 1.5, rescales each tap pair with a bit-serial divider. After reset
// the same sweep loads the default taps and clears the ring, so no word is
// taken until the sweep ends; the channel count register is to be written
// only while no word is in flight. A result waits in an output register
// while the next word is taken.
module stereo_fir_convolver_core #(
	parameter int TAP_DEPTH = sfc_pkg::TAP_DEPTH_DEF,
	parameter int CHANNELS  = sfc_pkg::CHANNELS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sfc_cfg_if.sink    cfg,
	sfc_in_if.sink     din,
	sfc_out_if.source  dout
);
	import sfc_pkg::*;

	localparam int RING_SIZE = TAP_DEPTH * CHANNELS;
	localparam int TAW       = (TAP_DEPTH > 1) ? $clog2(TAP_DEPTH) : 1;
	localparam int TCW       = $clog2(TAP_DEPTH + 1);
	localparam int RAW       = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
	localparam int RCW       = $clog2(RING_SIZE + 1);
	localparam int PROD_W    = SMP_W + TAP_W;
	localparam int ACC_W     = PROD_W + TAW + 1;
	localparam int CC_RST    = (CHANNELS < 2) ? CHANNELS : 2;
	localparam int DCW       = $clog2(QUO_W);

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7FFF_FFFF);
	localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

	typedef enum logic [7:0] {
		S_CLEAR  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_MAC    = 8'b0000_0100,
		S_OUT    = 8'b0000_1000,
		S_PEAK   = 8'b0001_0000,
		S_SC_RD  = 8'b0010_0000,
		S_SC_LAT = 8'b0100_0000,
		S_DIV    = 8'b1000_0000
	} state_t;

	state_t                    state_q;
	logic [RCW-1:0]            cnt_q;
	logic                      clr_commit_q;
	logic [CC_W-1:0]           cc_q;
	logic [TAW-1:0]            wp_q;
	logic [TCW-1:0]            len_q;
	logic [CH_W-1:0]           ch_q;
	logic                      v_s1, v_s2, pv_s1;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic [TAP_W-1:0]          peak_q;
	logic [2*TAP_W-1:0]        tap_word_q;
	logic                      div_side_q, div_neg_q;
	logic [REM_W-1:0]          div_rem_q;
	logic [QUO_W-1:0]          div_low_q, div_quo_q;
	logic [DCW-1:0]            div_cnt_q;
	logic [TAP_W-1:0]          left_res_q;
	logic [OUT_W-1:0]          res_val_q;
	logic                      res_clip_q, res_byp_q;
	logic                      out_valid_q;
	logic [OUT_W-1:0]          out_val_q;
	logic                      out_clip_q, out_byp_q;

	// memories
	logic [2*TAP_W-1:0]  tap_mem [TAP_DEPTH];
	logic [2*TAP_W-1:0]  tap_rd_q, tap_wd;
	logic [TAW-1:0]      tap_wa, tap_ra;
	logic                tap_we;
	logic [SMP_W-1:0]    ring_mem [RING_SIZE];
	logic [SMP_W-1:0]    ring_rd_q, ring_wd;
	logic [RAW-1:0]      ring_wa, ring_ra;
	logic                ring_we;

	function automatic logic [RAW-1:0] ring_addr(input logic [TAW-1:0] pos,
		input logic [CC_W-1:0] cc, input logic [CH_W-1:0] ch);
		ring_addr = RAW'(32'(pos) * 32'(cc) + 32'(ch));
	endfunction

	function automatic logic [TAP_W-1:0] tap_abs(input logic [TAP_W-1:0] t);
		tap_abs = t[TAP_W-1] ? (~t + TAP_W'(1)) : t;
	endfunction

	// ---- input side decode
	logic              accept, in_bypass, load_ok;
	logic [TCW-1:0]    len_sat;
	logic [31:0]       back32;
	logic [TAW-1:0]    back_pos;
	logic              issuing, mac_done, pk_issue, pk_done;

	assign din.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign accept    = din.valid & din.ready;
	assign in_bypass = (32'(din.channel) >= 32'(cc_q)) || (32'(din.channel) >= CHANNELS);
	assign load_ok   = 32'(din.tap_index) < TAP_DEPTH;
	assign len_sat   = (32'(din.tap_length) > TAP_DEPTH) ? TCW'(TAP_DEPTH)
		: TCW'(din.tap_length);

	// ring slot of tap i walks backward from the write position
	assign back32   = (32'(wp_q) >= 32'(cnt_q)) ? 32'(wp_q) - 32'(cnt_q)
		: 32'(wp_q) + 32'(TAP_DEPTH) - 32'(cnt_q);
	assign back_pos = TAW'(back32);

	assign issuing  = (state_q == S_MAC) && (32'(cnt_q) < 32'(len_q));
	assign mac_done = (state_q == S_MAC) && !issuing && !v_s1 && !v_s2;
	assign pk_issue = (state_q == S_PEAK) && (32'(cnt_q) < 32'(len_q));
	assign pk_done  = (state_q == S_PEAK) && !pk_issue && !pv_s1;

	assign tap_ra  = TAW'(cnt_q);
	assign ring_ra = ring_addr(back_pos, cc_q, ch_q);

	// ---- MAC datapath
	logic signed [SMP_W-1:0]  smp_s;
	logic signed [TAP_W-1:0]  tap_sel;
	logic signed [ACC_W-1:0]  acc_sh;
	logic [OUT_W-1:0]         sat_val;
	logic                     sat_clip;

	assign smp_s   = ring_rd_q;
	assign tap_sel = (ch_q == CH_W'(1)) ? tap_rd_q[TAP_W-1:0] : tap_rd_q[2*TAP_W-1:TAP_W];
	assign acc_sh  = acc_q >>> 16;

	always_comb begin
		sat_clip = 1'b0;
		sat_val  = OUT_W'(acc_sh);
		if (acc_sh > SAT_HI) begin
			sat_clip = 1'b1;
			sat_val  = OUT_W'(SAT_HI);
		end else if (acc_sh < SAT_LO) begin
			sat_clip = 1'b1;
			sat_val  = OUT_W'(SAT_LO);
		end
	end

	// ---- peak scan
	logic [TAP_W-1:0] abs_l, abs_r, peak_n;

	assign abs_l = tap_abs(tap_rd_q[2*TAP_W-1:TAP_W]);
	assign abs_r = tap_abs(tap_rd_q[TAP_W-1:0]);

	always_comb begin
		peak_n = peak_q;
		if (abs_l > peak_n) peak_n = abs_l;
		if (abs_r > peak_n) peak_n = abs_r;
	end

	// ---- restoring divider, one quotient bit a cycle
	logic [REM_W-1:0]   trial, rem_n;
	logic               div_ge, div_last;
	logic [QUO_W-1:0]   quo_n;
	logic [TAP_W-1:0]   div_res;
	logic [TAP_W-1:0]   init_tap;
	logic [TAP_W-1:0]   init_mag;
	logic [DIVD_W-1:0]  init_n;

	assign trial    = {div_rem_q[REM_W-2:0], div_low_q[QUO_W-1]};
	assign div_ge   = trial >= REM_W'(peak_q);
	assign rem_n    = div_ge ? (trial - REM_W'(peak_q)) : trial;
	assign quo_n    = {div_quo_q[QUO_W-2:0], div_ge};
	assign div_last = (div_cnt_q == DCW'(QUO_W - 1));
	assign div_res  = div_neg_q ? (~TAP_W'(quo_n) + TAP_W'(1)) : TAP_W'(quo_n);

	// next division operand: left from fresh read data, right from the held word
	assign init_tap = (state_q == S_SC_LAT) ? tap_rd_q[2*TAP_W-1:TAP_W] : tap_word_q[TAP_W-1:0];
	assign init_mag = tap_abs(init_tap);
	assign init_n   = (DIVD_W'(init_mag) << 16) + DIVD_W'(peak_q >> 1);

	// ---- memory write ports
	always_comb begin
		tap_we  = 1'b0;
		tap_wa  = TAW'(cnt_q);
		tap_wd  = '0;
		ring_we = 1'b0;
		ring_wa = RAW'(cnt_q);
		ring_wd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && din.cmd == CMD_LOAD && load_ok) begin
					tap_we = 1'b1;
					tap_wa = TAW'(din.tap_index);
					tap_wd = {din.tap_left, din.tap_right};
				end
				if (accept && din.cmd == CMD_SAMPLE && !in_bypass) begin
					ring_we = 1'b1;
					ring_wa = ring_addr(wp_q, cc_q, din.channel);
					ring_wd = din.sample_in;
				end
			end
			S_CLEAR: begin
				ring_we = 1'b1;
				if (32'(cnt_q) < TAP_DEPTH) begin
					if (!clr_commit_q) begin
						tap_we = 1'b1;
						if (cnt_q == '0)
							tap_wd = {TAP_W'(ONE_Q16), TAP_W'(ONE_Q16)};
					end else if (32'(cnt_q) >= 32'(len_q)) begin
						tap_we = 1'b1;
					end
				end
			end
			S_DIV: begin
				if (div_last && div_side_q) begin
					tap_we = 1'b1;
					tap_wd = {left_res_q, div_res};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tap_we)
			tap_mem[tap_wa] <= tap_wd;
		tap_rd_q <= tap_mem[tap_ra];
	end

	always_ff @(posedge clk) begin
		if (ring_we)
			ring_mem[ring_wa] <= ring_wd;
		ring_rd_q <= ring_mem[ring_ra];
	end

	// ---- pipeline payload
	always_ff @(posedge clk) begin
		prod_s2 <= smp_s * tap_sel;
		if (state_q == S_SC_LAT)
			tap_word_q <= tap_rd_q;
	end

	// ---- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			cnt_q        <= '0;
			clr_commit_q <= 1'b0;
			cc_q         <= CC_W'(CC_RST);
			wp_q         <= '0;
			len_q        <= TCW'(1);
			ch_q         <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			pv_s1        <= 1'b0;
			acc_q        <= '0;
			peak_q       <= '0;
			div_side_q   <= 1'b0;
			div_neg_q    <= 1'b0;
			div_rem_q    <= '0;
			div_low_q    <= '0;
			div_quo_q    <= '0;
			div_cnt_q    <= '0;
			left_res_q   <= '0;
			res_val_q    <= '0;
			res_clip_q   <= 1'b0;
			res_byp_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			out_val_q    <= '0;
			out_clip_q   <= 1'b0;
			out_byp_q    <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready && cfg.data != '0 && 32'(cfg.data) <= CHANNELS)
				cc_q <= cfg.data;

			// S_OUT either reloads the output register or keeps it full
			if (dout.ready && state_q != S_OUT)
				out_valid_q <= 1'b0;

			v_s1  <= issuing;
			v_s2  <= v_s1;
			pv_s1 <= pk_issue;
			if (v_s2)
				acc_q <= acc_q + ACC_W'(prod_s2);
			if (pv_s1)
				peak_q <= peak_n;

			unique case (state_q)
				S_CLEAR: begin
					if (32'(cnt_q) == RING_SIZE - 1) begin
						cnt_q   <= '0;
						peak_q  <= '0;
						state_q <= clr_commit_q ? S_PEAK : S_IDLE;
					end else begin
						cnt_q <= cnt_q + RCW'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (din.cmd)
							CMD_SAMPLE: begin
								if (in_bypass) begin
									res_val_q  <= OUT_W'(din.sample_in);
									res_clip_q <= 1'b0;
									res_byp_q  <= 1'b1;
									state_q    <= S_OUT;
								end else begin
									ch_q    <= din.channel;
									cnt_q   <= '0;
									acc_q   <= '0;
									state_q <= S_MAC;
								end
							end
							CMD_ADVANCE: begin
								wp_q <= (32'(wp_q) == TAP_DEPTH - 1) ? '0 : wp_q + TAW'(1);
							end
							CMD_LOAD: ;
							CMD_COMMIT: begin
								if (len_sat != '0) begin
									len_q        <= len_sat;
									wp_q         <= '0;
									clr_commit_q <= 1'b1;
									cnt_q        <= '0;
									state_q      <= S_CLEAR;
								end
							end
							default: ;
						endcase
					end
				end
				S_MAC: begin
					if (issuing)
						cnt_q <= cnt_q + RCW'(1);
					if (mac_done) begin
						res_val_q  <= sat_val;
						res_clip_q <= sat_clip;
						res_byp_q  <= 1'b0;
						state_q    <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || dout.ready) begin
						out_valid_q <= 1'b1;
						out_val_q   <= res_val_q;
						out_clip_q  <= res_clip_q;
						out_byp_q   <= res_byp_q;
						state_q     <= S_IDLE;
					end
				end
				S_PEAK: begin
					if (pk_issue)
						cnt_q <= cnt_q + RCW'(1);
					if (pk_done) begin
						cnt_q   <= '0;
						state_q <= (32'(peak_q) > PEAK_LIMIT) ? S_SC_RD : S_IDLE;
					end
				end
				S_SC_RD: begin
					state_q <= S_SC_LAT;
				end
				S_SC_LAT: begin
					div_side_q <= 1'b0;
					div_neg_q  <= init_tap[TAP_W-1];
					div_rem_q  <= REM_W'(init_n >> QUO_W);
					div_low_q  <= init_n[QUO_W-1:0];
					div_quo_q  <= '0;
					div_cnt_q  <= '0;
					state_q    <= S_DIV;
				end
				S_DIV: begin
					if (div_last && !div_side_q) begin
						// left done, start the right tap
						left_res_q <= div_res;
						div_side_q <= 1'b1;
						div_neg_q  <= init_tap[TAP_W-1];
						div_rem_q  <= REM_W'(init_n >> QUO_W);
						div_low_q  <= init_n[QUO_W-1:0];
						div_quo_q  <= '0;
						div_cnt_q  <= '0;
					end else begin
						div_rem_q <= rem_n;
						div_low_q <= div_low_q << 1;
						div_quo_q <= quo_n;
						div_cnt_q <= div_cnt_q + DCW'(1);
						if (div_last) begin
							cnt_q   <= cnt_q + RCW'(1);
							state_q <= (32'(cnt_q) + 1 == 32'(len_q)) ? S_IDLE : S_SC_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign dout.valid      = out_valid_q;
	assign dout.sample_out = out_val_q;
	assign dout.clipped    = out_clip_q;
	assign dout.bypassed   = out_byp_q;

endmodule

@@ tb/sfc_tb_if.sv @@
// ----------------------------------------------------------------------------
// sfc_tb_if
// Word types the testbench keeps for the convolver's handshake channels.
// ----------------------------------------------------------------------------
// The RTL interfaces already carry source and sink modports; this file holds
// the word types the testbench keeps in its queues.
package sfc_tb_pkg;
	import sfc_pkg::*;

	typedef struct {
		cmd_t                    cmd;
		logic [CH_W-1:0]         channel;
		logic signed [SMP_W-1:0] sample_in;
		logic [TIDX_W-1:0]       tap_index;
		logic signed [TAP_W-1:0] tap_left;
		logic signed [TAP_W-1:0] tap_right;
		logic [TLEN_W-1:0]       tap_length;
	} in_word_t;

	typedef struct {
		logic signed [OUT_W-1:0] sample_out;
		logic                    clipped;
		logic                    bypassed;
	} out_word_t;

endpackage

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stereo FIR convolver core.
// ----------------------------------------------------------------------------
// Words are predicted by a behavioral filter model as the driver hands them
// over; the monitor compares every output word against the oldest prediction.
// Random idling on both sides, a long output hold-off and a drain pause.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sfc_pkg::*;
	import sfc_tb_pkg::*;

	localparam int DEPTH = TAP_DEPTH_DEF;
	localparam int NCH   = CHANNELS_DEF;
	localparam int LIMIT = 6000000;

	logic clk;
	logic arst_n;

	sfc_cfg_if cfg();
	sfc_in_if  din();
	sfc_out_if dout();

	stereo_fir_convolver_core DUT (.clk(clk), .arst_n(arst_n), .cfg(cfg), .din(din),
		.dout(dout));

	// filter model state
	int    m_left [DEPTH];
	int    m_right[DEPTH];
	int    m_ring [DEPTH*NCH];
	int    m_wpos;
	int    m_len;
	int    m_chans;

	in_word_t  pending[$];
	out_word_t expected[$];

	int    errors, mismatches, results, clips, bypasses, commits, scaled;
	int    cycles = 0;
	bit    quiet;          // no idling in the last part
	bit    send_pause;
	bit    hold_out;       // long receiver hold-off
	int    in_gap, out_gap;
	bit    stim_done;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int scale_tap(int t, int peak);
		longint mag, q;
		mag = t < 0 ? -t : t;
		q = (mag * ONE_Q16 + peak / 2) / peak;
		return t < 0 ? -int'(q) : int'(q);
	endfunction

	function automatic void commit_taps(int len);
		int peak, a, b;
		peak = 0;
		if (len == 0)
			return;
		if (len > DEPTH)
			len = DEPTH;
		for (int i = len; i < DEPTH; i++) begin
			m_left[i] = 0;
			m_right[i] = 0;
		end
		foreach (m_ring[i])
			m_ring[i] = 0;
		m_len = len;
		m_wpos = 0;
		commits++;
		for (int i = 0; i < len; i++) begin
			a = m_left[i] < 0 ? -m_left[i] : m_left[i];
			b = m_right[i] < 0 ? -m_right[i] : m_right[i];
			if (a > peak) peak = a;
			if (b > peak) peak = b;
		end
		if (peak > PEAK_LIMIT) begin
			scaled++;
			for (int i = 0; i < len; i++) begin
				m_left[i] = scale_tap(m_left[i], peak);
				m_right[i] = scale_tap(m_right[i], peak);
			end
		end
	endfunction

	function automatic void filter_word(in_word_t w);
		out_word_t r;
		longint acc, y;
		int idx;
		case (w.cmd)
			CMD_ADVANCE: m_wpos = (m_wpos + 1) % DEPTH;
			CMD_LOAD: begin
				m_left[w.tap_index] = int'(w.tap_left);
				m_right[w.tap_index] = int'(w.tap_right);
			end
			CMD_COMMIT: commit_taps(int'(w.tap_length));
			default: begin
				if (w.channel >= m_chans || w.channel >= NCH) begin
					r.sample_out = OUT_W'(w.sample_in);
					r.clipped = 1'b0;
					r.bypassed = 1'b1;
				end else begin
					acc = 0;
					m_ring[(m_wpos * m_chans + w.channel) % (DEPTH*NCH)] = int'(w.sample_in);
					for (int i = 0; i < m_len; i++) begin
						idx = m_wpos >= i ? m_wpos - i : m_wpos + DEPTH - i;
						acc += longint'(m_ring[(idx * m_chans + w.channel) % (DEPTH*NCH)]) *
							longint'(w.channel == 1 ? m_right[i] : m_left[i]);
					end
					y = acc >>> 16;
					r.clipped = 1'b0;
					if (y > 64'sd2147483647) begin
						y = 64'sd2147483647;
						r.clipped = 1'b1;
					end
					if (y < -64'sd2147483648) begin
						y = -64'sd2147483648;
						r.clipped = 1'b1;
					end
					r.sample_out = y[31:0];
					r.bypassed = 1'b0;
				end
				expected.push_back(r);
			end
		endcase
	endfunction

	// driver: predicts at acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			din.valid <= 1'b0;
			din.cmd <= CMD_SAMPLE;
			din.channel <= '0;
			din.sample_in <= '0;
			din.tap_index <= '0;
			din.tap_left <= '0;
			din.tap_right <= '0;
			din.tap_length <= '0;
			in_gap <= 0;
		end else begin
			if (din.valid && din.ready) begin
				filter_word(pending.pop_front());
			end
			if (din.valid && !din.ready) begin
				// hold the offered word
			end else if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				din.valid <= 1'b0;
			end else if (pending.size() > 0 && !send_pause &&
					(quiet || $urandom_range(0, 15) != 0)) begin
				din.valid <= 1'b1;
				din.cmd <= pending[0].cmd;
				din.channel <= pending[0].channel;
				din.sample_in <= pending[0].sample_in;
				din.tap_index <= pending[0].tap_index;
				din.tap_left <= pending[0].tap_left;
				din.tap_right <= pending[0].tap_right;
				din.tap_length <= pending[0].tap_length;
			end else begin
				din.valid <= 1'b0;
				if (!quiet && $urandom_range(0, 3) == 0)
					in_gap <= $urandom_range(1, 11);
			end
		end
	end

	// monitor and output stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout.ready <= 1'b0;
			out_gap <= 0;
		end else begin
			if (dout.valid && dout.ready) begin
				results++;
				if (expected.size() == 0) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected output word %0d", dout.sample_out);
				end else begin
					out_word_t e;
					e = expected.pop_front();
					if (e.sample_out !== dout.sample_out || e.clipped !== dout.clipped ||
							e.bypassed !== dout.bypassed) begin
						errors++;
						mismatches++;
						if (mismatches <= 10)
							$display("word %0d: exp %0d/%b/%b got %0d/%b/%b", results,
								e.sample_out, e.clipped, e.bypassed, dout.sample_out,
								dout.clipped, dout.bypassed);
					end
					clips += e.clipped;
					bypasses += e.bypassed;
				end
			end
			if (hold_out) begin
				dout.ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				dout.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 12) == 0) begin
				out_gap <= $urandom_range(1, 11);
				dout.ready <= 1'b0;
			end else begin
				dout.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic in_word_t rand_word();
		in_word_t w;
		w.cmd = CMD_SAMPLE;
		w.channel = CH_W'($urandom_range(0, 7));
		w.sample_in = SMP_W'($urandom);
		w.tap_index = TIDX_W'($urandom);
		w.tap_left = TAP_W'($urandom);
		w.tap_right = TAP_W'($urandom);
		w.tap_length = TLEN_W'($urandom);
		return w;
	endfunction

	function automatic void add(cmd_t c, int ch, int smp, int ti, int tl, int tr, int len);
		in_word_t w;
		w = rand_word();
		w.cmd = c;
		if (c == CMD_SAMPLE) begin
			w.channel = CH_W'(ch);
			w.sample_in = SMP_W'(smp);
		end
		if (c == CMD_LOAD) begin
			w.tap_index = TIDX_W'(ti);
			w.tap_left = TAP_W'(tl);
			w.tap_right = TAP_W'(tr);
		end
		if (c == CMD_COMMIT)
			w.tap_length = TLEN_W'(len);
		pending.push_back(w);
	endfunction

	task automatic wait_idle();
		while (pending.size() > 0 || din.valid || expected.size() > 0)
			@(posedge clk);
		// commit may still be sweeping
		repeat (DEPTH*NCH + 2*DEPTH*40 / 16 + 200) @(posedge clk);
	endtask

	task automatic write_count(int v);
		cfg.data <= CC_W'(v);
		cfg.valid <= 1'b1;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		if (v >= 1 && v <= NCH)
			m_chans = v;
	endtask

	// one random filter setup followed by samples
	task automatic random_block(int nsamp, int maxlen, bit big);
		int len;
		len = $urandom_range(1, maxlen);
		for (int i = 0; i < len; i++)
			add(CMD_LOAD, 0, 0, i, big ? $urandom : $signed(19'($urandom_range(0, 16383))) -
				8192, big ? $urandom : $urandom_range(0, 16383) - 8192, 0);
		if ($urandom_range(0, 4) == 0)
			add(CMD_LOAD, 0, 0, $urandom, $urandom, $urandom, 0);
		add(CMD_COMMIT, 0, 0, 0, 0, 0, len);
		for (int i = 0; i < nsamp; i++) begin
			case ($urandom_range(0, 9))
				0: add(CMD_ADVANCE, 0, 0, 0, 0, 0, 0);
				1: add(CMD_SAMPLE, $urandom_range(2, 7), $urandom, 0, 0, 0, 0);
				default: begin
					add(CMD_SAMPLE, $urandom_range(0, 1), $urandom, 0, 0, 0, 0);
					if ($urandom_range(0, 1)) add(CMD_ADVANCE, 0, 0, 0, 0, 0, 0);
				end
			endcase
		end
	endtask

	initial begin
		in_word_t w;
		foreach (m_left[i]) begin
			m_left[i] = 0;
			m_right[i] = 0;
		end
		foreach (m_ring[i]) m_ring[i] = 0;
		m_left[0] = ONE_Q16;
		m_right[0] = ONE_Q16;
		m_wpos = 0;
		m_len = 1;
		m_chans = NCH < 2 ? NCH : 2;
		quiet = 0;
		send_pause = 0;
		hold_out = 0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset taps pass samples, extremes, bypass, specials
		add(CMD_SAMPLE, 0, 24'sh7FFFFF, 0, 0, 0, 0);
		add(CMD_SAMPLE, 1, -8388608, 0, 0, 0, 0);
		add(CMD_SAMPLE, 7, -8388608, 0, 0, 0, 0);
		add(CMD_SAMPLE, 2, 24'sh7FFFFF, 0, 0, 0, 0);
		add(CMD_ADVANCE, 0, 0, 0, 0, 0, 0);
		add(CMD_LOAD, 0, 0, 0, 262143, -262144, 0);
		add(CMD_LOAD, 0, 0, 1023, -262144, 262143, 0);
		add(CMD_COMMIT, 0, 0, 0, 0, 0, 0);
		add(CMD_COMMIT, 0, 0, 0, 0, 0, 2047);
		add(CMD_SAMPLE, 0, 24'sh7FFFFF, 0, 0, 0, 0);
		add(CMD_SAMPLE, 1, -8388608, 0, 0, 0, 0);
		for (int i = 0; i < 8; i++)
			add(CMD_LOAD, 0, 0, i, 98304, -98304, 0);
		add(CMD_COMMIT, 0, 0, 0, 0, 0, 8);
		for (int i = 0; i < 5; i++) begin
			add(CMD_SAMPLE, 0, 24'sh7FFFFF, 0, 0, 0, 0);
			add(CMD_SAMPLE, 1, 24'sh7FFFFF, 0, 0, 0, 0);
			add(CMD_ADVANCE, 0, 0, 0, 0, 0, 0);
		end
		wait_idle();
		write_count(0);
		write_count(3);
		write_count(1);
		add(CMD_SAMPLE, 1, 1234, 0, 0, 0, 0);
		add(CMD_SAMPLE, 0, -1234, 0, 0, 0, 0);

		// random setups, channel count changed between phases
		for (int blk = 0; blk < 14; blk++) begin
			random_block(15, blk % 5 == 4 ? 64 : 24, blk % 2);
			if (blk == 3) begin
				// receiver holds off while the sender keeps offering
				while (pending.size() > 0 && din.valid == 0) @(posedge clk);
				hold_out = 1'b1;
				repeat (400) @(posedge clk);
				hold_out = 1'b0;
			end
			if (blk == 6) begin
				send_pause = 1'b1;
				while (expected.size() > 0) @(posedge clk);
				send_pause = 1'b0;
			end
			if (blk % 4 == 2) begin
				wait_idle();
				write_count($urandom_range(1, 2));
			end
			if (blk == 10) begin
				wait_idle();
				write_count(2);
				quiet = 1'b1;
			end
		end
		while (pending.size() > 0 || expected.size() > 0) @(posedge clk);
		repeat (DEPTH + 50) @(posedge clk);
		$display("%0d words checked, %0d clipped, %0d bypassed, %0d commits (%0d rescaled)",
			results, clips, bypasses, commits, scaled);
		if (errors == 0 && expected.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/sfc_pkg.sv
hw/rtl/sfc_in_if.sv
hw/rtl/sfc_out_if.sv
hw/rtl/sfc_cfg_if.sv
hw/rtl/stereo_fir_convolver_core.sv
tb/sfc_tb_if.sv
tb/tb_top.sv
